// ===== hw/rtl/sdsh_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsh_pkg
// Types, phase codes and step table of the SD card SPI host sequencer.
// ----------------------------------------------------------------------------
package sdsh_pkg;

    localparam int unsigned BLOCK_BYTES = 512;

    typedef enum logic [2:0] {
        REQ_INIT  = 3'd0,
        REQ_WAKE  = 3'd1,
        REQ_READ  = 3'd2,
        REQ_WRITE = 3'd3,
        REQ_LINK  = 3'd4,
        REQ_TICK  = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        CFG_POLL   = 2'd0,
        CFG_RETRY  = 2'd1,
        CFG_TPOLL  = 2'd2,
        CFG_ROUNDS = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERROR = 2'd1,
        ST_NRDY  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        K_NONE, K_FF, K_FRAME, K_R1, K_TICK, K_TOKEN, K_WDATA, K_BUSY
    } kind_t;

    typedef enum logic [1:0] { A_ZERO, A_VOLT, A_HCS, A_ADDR } arg_t;

    typedef enum logic [5:0] {
        P_IDLE,
        P_IN_WAKE, P_IN_CMD0, P_IN_R1A, P_IN_GAPA, P_IN_CMD8, P_IN_R1B,
        P_V1_C55, P_V1_R1A, P_V1_GAPA, P_V1_ACMD, P_V1_R1B, P_V1_GAPB, P_V1_TICK,
        P_MM_CMD1, P_MM_R1, P_MM_GAP, P_MM_TICK,
        P_V2_SKIP, P_V2_GAP,
        P_V2_C55A, P_V2_R1A, P_V2_GAPA, P_V2_C55B, P_V2_R1B,
        P_V2_C55C, P_V2_R1C, P_V2_GAPC, P_V2_ACMD, P_V2_R1D, P_V2_GAPD, P_V2_TICK,
        P_V2_CMD58, P_V2_R1E, P_V2_OCR, P_V2_GAPE,
        P_WK_CMD1, P_WK_R1A, P_WK_GAPA, P_WK_TICKA,
        P_WK_C55, P_WK_R1B, P_WK_GAPB, P_WK_ACMD, P_WK_R1C, P_WK_GAPC, P_WK_TICKB,
        P_RD_CMD, P_RD_R1, P_RD_TOKEN, P_RD_TICK, P_RD_DATA, P_RD_CRC, P_RD_GAP,
        P_WR_CMD, P_WR_R1, P_WR_GAPA, P_WR_TOKEN, P_WR_DATA, P_WR_CRC, P_WR_RESP,
        P_WR_BUSY, P_WR_GAPB
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic       cs;
        logic [7:0] tx;
        logic [7:0] cmd;
        logic [7:0] crc;
        arg_t       arg;
        logic [9:0] count;
    } step_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [31:0] sector;
        logic [7:0] rx_byte;
        logic [7:0] wr_data;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_active;
        logic       fast_clock;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       want_data;
        logic       wait_tick;
        logic       done_res;
        logic [1:0] status;
        logic [2:0] card_type;
    } out_item_t;

    typedef struct packed {
        logic [3:0] poll_limit;
        logic [9:0] retry_limit;
        logic [3:0] tpoll_limit;
        logic [2:0] rounds;
    } cfg_t;

    function automatic step_t mk(kind_t k, logic cs, logic [7:0] tx, logic [7:0] cmd,
                                 logic [7:0] crc, arg_t a, logic [9:0] n);
        step_t s;
        s.kind = k; s.cs = cs; s.tx = tx; s.cmd = cmd; s.crc = crc; s.arg = a; s.count = n;
        return s;
    endfunction

    function automatic step_t sff(logic [9:0] n, logic cs);
        return mk(K_FF, cs, 8'hFF, 8'h00, 8'h00, A_ZERO, n);
    endfunction

    function automatic step_t scmd(logic [7:0] m, arg_t a, logic [7:0] r);
        return mk(K_FRAME, 1'b1, 8'h00, m, r, a, 10'd6);
    endfunction

    function automatic step_t step_of(phase_t p);
        step_t s;
        unique case (p)
            P_IN_WAKE:  s = sff(10'd10, 1'b0);
            P_IN_CMD0:  s = scmd(8'h40, A_ZERO, 8'h95);
            P_IN_GAPA:  s = sff(10'd1, 1'b1);
            P_IN_CMD8:  s = scmd(8'h48, A_VOLT, 8'h87);
            P_V1_C55:   s = scmd(8'h77, A_ZERO, 8'h00);
            P_V1_GAPA:  s = sff(10'd1, 1'b0);
            P_V1_ACMD:  s = scmd(8'h69, A_HCS, 8'h00);
            P_V1_GAPB:  s = sff(10'd1, 1'b1);
            P_MM_CMD1:  s = scmd(8'h41, A_ZERO, 8'h00);
            P_MM_GAP:   s = sff(10'd1, 1'b1);
            P_V2_SKIP:  s = sff(10'd4, 1'b1);
            P_V2_GAP:   s = sff(10'd1, 1'b1);
            P_V2_C55A:  s = scmd(8'h77, A_ZERO, 8'h00);
            P_V2_GAPA:  s = sff(10'd1, 1'b0);
            P_V2_C55B:  s = scmd(8'h77, A_ZERO, 8'h00);
            P_V2_C55C:  s = scmd(8'h77, A_ZERO, 8'h00);
            P_V2_GAPC:  s = sff(10'd1, 1'b0);
            P_V2_ACMD:  s = scmd(8'h69, A_HCS, 8'h77);
            P_V2_GAPD:  s = sff(10'd1, 1'b1);
            P_V2_CMD58: s = scmd(8'h7A, A_ZERO, 8'h95);
            P_V2_OCR:   s = sff(10'd4, 1'b1);
            P_V2_GAPE:  s = sff(10'd1, 1'b1);
            P_WK_CMD1:  s = scmd(8'h41, A_ZERO, 8'h00);
            P_WK_GAPA:  s = sff(10'd1, 1'b1);
            P_WK_C55:   s = scmd(8'h77, A_ZERO, 8'h00);
            P_WK_GAPB:  s = sff(10'd1, 1'b0);
            P_WK_ACMD:  s = scmd(8'h69, A_HCS, 8'h00);
            P_WK_GAPC:  s = sff(10'd1, 1'b1);
            P_RD_CMD:   s = scmd(8'h51, A_ADDR, 8'h00);
            P_RD_TOKEN: s = mk(K_TOKEN, 1'b1, 8'hFF, 8'h00, 8'h00, A_ZERO, 10'd1);
            P_RD_DATA:  s = sff(10'(BLOCK_BYTES), 1'b1);
            P_RD_CRC:   s = sff(10'd2, 1'b1);
            P_RD_GAP:   s = sff(10'd1, 1'b1);
            P_WR_CMD:   s = scmd(8'h58, A_ADDR, 8'h00);
            P_WR_GAPA:  s = sff(10'd1, 1'b1);
            P_WR_TOKEN: s = mk(K_FF, 1'b1, 8'hFE, 8'h00, 8'h00, A_ZERO, 10'd1);
            P_WR_DATA:  s = mk(K_WDATA, 1'b1, 8'h00, 8'h00, 8'h00, A_ZERO,
                               10'(BLOCK_BYTES));
            P_WR_CRC:   s = mk(K_FF, 1'b1, 8'h00, 8'h00, 8'h00, A_ZERO, 10'd2);
            P_WR_RESP:  s = sff(10'd1, 1'b1);
            P_WR_BUSY:  s = mk(K_BUSY, 1'b1, 8'hFF, 8'h00, 8'h00, A_ZERO, 10'd1);
            P_WR_GAPB:  s = sff(10'd1, 1'b1);
            P_IN_R1A, P_IN_R1B, P_V1_R1A, P_V1_R1B, P_MM_R1, P_V2_R1A, P_V2_R1B,
            P_V2_R1C, P_V2_R1D, P_V2_R1E, P_WK_R1A, P_WK_R1B, P_WK_R1C, P_RD_R1,
            P_WR_R1:
                s = mk(K_R1, 1'b1, 8'hFF, 8'h00, 8'h00, A_ZERO, 10'd1);
            P_V1_TICK, P_MM_TICK, P_V2_TICK, P_WK_TICKA, P_WK_TICKB, P_RD_TICK:
                s = mk(K_TICK, 1'b0, 8'h00, 8'h00, 8'h00, A_ZERO, 10'd0);
            default:    s = mk(K_NONE, 1'b0, 8'h00, 8'h00, 8'h00, A_ZERO, 10'd0);
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/sdsh_if.sv =====
// ----------------------------------------------------------------------------
// sdsh_if
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------
interface sdsh_in_if import sdsh_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sdsh_out_if import sdsh_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sdsh_cfg_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/sdsh_core.sv =====
// ----------------------------------------------------------------------------
// sdsh_core
// Sequencer state and next-state logic: one item in, one result out.
// ----------------------------------------------------------------------------
module sdsh_core
    import sdsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t res
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  kind_reg, kind_next;
    logic [9:0]  retry_reg, retry_next;
    logic [3:0]  poll_reg, poll_next;
    logic [2:0]  round_reg, round_next;
    logic [9:0]  bcnt_reg, bcnt_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  resp_reg, resp_next;
    logic [7:0]  ocr_reg, ocr_next;
    logic        fast_reg, fast_next;

    step_t       s_cur, s_new;
    out_item_t   rdo;
    logic        fin;
    logic [1:0]  fin_st;
    logic [2:0]  fin_ty;
    logic        act;
    logic [7:0]  rx;
    logic [7:0]  r;
    logic [9:0]  bc1;
    logic [3:0]  pc1;
    logic [31:0] argv;
    logic [7:0]  fb;
    logic        want;
    phase_t      cphase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            kind_reg  <= 3'd0;
            retry_reg <= '0;
            poll_reg  <= '0;
            round_reg <= '0;
            bcnt_reg  <= '0;
            addr_reg  <= '0;
            resp_reg  <= 8'hFF;
            ocr_reg   <= '0;
            fast_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            retry_reg <= retry_next;
            poll_reg  <= poll_next;
            round_reg <= round_next;
            bcnt_reg  <= bcnt_next;
            addr_reg  <= addr_next;
            resp_reg  <= resp_next;
            ocr_reg   <= ocr_next;
            fast_reg  <= fast_next;
        end
    end

    assign s_cur = step_of(phase_reg);
    assign rx    = item.rx_byte;
    assign r     = resp_next;
    assign bc1   = bcnt_reg + 10'd1;
    assign pc1   = poll_reg + 4'd1;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        retry_next = retry_reg;
        poll_next  = poll_reg;
        round_next = round_reg;
        bcnt_next  = bcnt_reg;
        addr_next  = addr_reg;
        resp_next  = resp_reg;
        ocr_next   = ocr_reg;
        fast_next  = fast_reg;
        fin        = 1'b0;
        fin_st     = ST_OK;
        fin_ty     = 3'd0;
        act        = 1'b0;
        rdo        = '0;
        cphase     = phase_reg;

        priority if (phase_reg == P_IDLE && item.req_type <= REQ_WRITE)
        begin
            act = 1'b1;
            poll_next = '0;
            bcnt_next = '0;
            priority if (item.req_type == REQ_INIT)
            begin
                fast_next = 1'b0;
                phase_next = P_IN_WAKE;
            end
            else if (item.req_type == REQ_WAKE)
            begin
                if (kind_reg == 3'd0)
                begin
                    fin = 1'b1; fin_st = ST_NRDY;
                end
                else
                begin
                    fast_next = 1'b0;
                    retry_next = '0;
                    phase_next = (kind_reg == 3'd1 || kind_reg == 3'd2) ? P_WK_CMD1 : P_WK_C55;
                end
            end
            else
            begin
                fast_next = 1'b1;
                round_next = '0;
                addr_next = (kind_reg == 3'd4) ? item.sector : {item.sector[22:0], 9'd0};
                phase_next = (item.req_type == REQ_READ) ? P_RD_CMD : P_WR_CMD;
            end
        end
        else if (item.req_type == REQ_LINK && s_cur.kind != K_NONE && s_cur.kind != K_TICK)
        begin
            act = 1'b1;
            cphase = P_IDLE;
            unique case (s_cur.kind)
                K_FF, K_FRAME, K_WDATA:
                begin
                    if (phase_reg == P_RD_DATA)
                    begin
                        rdo.rd_valid = 1'b1; rdo.rd_byte = rx;
                    end
                    if (phase_reg == P_V2_OCR && bcnt_reg == 10'd0)
                        ocr_next = rx;
                    bcnt_next = bc1;
                    if (bc1 >= s_cur.count)
                        cphase = phase_reg;
                end
                K_R1:
                begin
                    if (!rx[7])
                    begin
                        resp_next = rx; cphase = phase_reg;
                    end
                    else
                    begin
                        poll_next = pc1;
                        if (pc1 >= cfg.poll_limit)
                            fin = 1'b1;
                    end
                end
                K_TOKEN:
                begin
                    if (rx == 8'hFE)
                        cphase = phase_reg;
                    else
                    begin
                        poll_next = pc1;
                        if (pc1 >= cfg.tpoll_limit)
                        begin
                            round_next = round_reg + 3'd1;
                            phase_next = P_RD_TICK; bcnt_next = '0; poll_next = '0;
                        end
                    end
                end
                K_BUSY:
                    if (rx != 8'h00)
                        cphase = phase_reg;
                default: ;
            endcase
            if (cphase != P_IDLE)
            begin
                // completion of the current step
                bcnt_next = '0; poll_next = '0;
                phase_next = phase_t'(phase_reg + 6'd1);
                unique case (phase_reg)
                    P_IN_R1B:
                        if (r[2])
                        begin
                            retry_next = '0; phase_next = P_V1_C55;
                        end
                        else phase_next = P_V2_SKIP;
                    P_V1_GAPB:
                        if (r[2])
                        begin
                            retry_next = '0; phase_next = P_MM_CMD1;
                        end
                        else if (r == 8'h00)
                        begin
                            kind_next = 3'd1; fast_next = 1'b1; fin = 1'b1;
                            fin_ty = 3'd1;
                        end
                        else phase_next = P_V1_TICK;
                    P_MM_GAP:
                        if (r == 8'h00)
                        begin
                            kind_next = 3'd2; fast_next = 1'b1; fin = 1'b1;
                            fin_ty = 3'd2;
                        end
                        else phase_next = P_MM_TICK;
                    P_V2_GAP:
                    begin
                        retry_next = '0; phase_next = P_V2_C55A;
                    end
                    P_V2_R1B:
                        if (r == 8'h01) phase_next = P_V2_C55C;
                        else if (r == 8'h00) phase_next = P_V2_CMD58;
                        else
                        begin
                            fin = 1'b1; fin_st = ST_ERROR;
                        end
                    P_V2_GAPD:
                        phase_next = (r == 8'h00) ? P_V2_CMD58 : P_V2_TICK;
                    P_V2_GAPE:
                    begin
                        kind_next = ocr_next[6] ? 3'd4 : 3'd3;
                        fast_next = 1'b1; fin = 1'b1;
                        fin_ty = kind_next;
                    end
                    P_WK_GAPA, P_WK_GAPC:
                        if (r == 8'h00)
                        begin
                            fin = 1'b1; fin_ty = kind_reg;
                        end
                    P_RD_R1, P_WR_R1:
                        if (r != 8'h00)
                        begin
                            fin = 1'b1; fin_st = ST_ERROR; fin_ty = kind_reg;
                        end
                    P_RD_GAP, P_WR_GAPB:
                    begin
                        fin = 1'b1; fin_ty = kind_reg;
                    end
                    P_WR_RESP:
                        if (rx[4] || rx[3:0] != 4'b0101)
                        begin
                            fin = 1'b1; fin_st = ST_ERROR; fin_ty = kind_reg;
                        end
                        else phase_next = P_WR_BUSY;
                    default: ;
                endcase
            end
            else if (fin)
            begin
                // R1 poll timeout
                if (phase_reg <= P_V2_GAPE)
                begin
                    fin_st = ST_ERROR; fin_ty = 3'd0;
                end
                else if (phase_reg <= P_WK_TICKB)
                begin
                    fin_st = ST_NRDY; fin_ty = kind_reg;
                end
                else
                begin
                    fin_st = ST_ERROR; fin_ty = kind_reg;
                end
            end
        end
        else if (item.req_type == REQ_TICK && s_cur.kind == K_TICK)
        begin
            act = 1'b1;
            bcnt_next = '0; poll_next = '0;
            if (phase_reg == P_RD_TICK)
            begin
                if (round_reg >= cfg.rounds)
                begin
                    fin = 1'b1; fin_st = ST_ERROR; fin_ty = kind_reg;
                end
                else phase_next = P_RD_TOKEN;
            end
            else
            begin
                retry_next = retry_reg + 10'd1;
                if (retry_next >= cfg.retry_limit)
                begin
                    fin = 1'b1;
                    if (phase_reg <= P_V2_GAPE) fin_st = ST_ERROR;
                    else
                    begin
                        fin_st = ST_NRDY; fin_ty = kind_reg;
                    end
                end
                else
                    unique case (phase_reg)
                        P_V1_TICK:  phase_next = P_V1_C55;
                        P_MM_TICK:  phase_next = P_MM_CMD1;
                        P_V2_TICK:  phase_next = P_V2_C55A;
                        P_WK_TICKA: phase_next = P_WK_CMD1;
                        default:    phase_next = P_WK_C55;
                    endcase
            end
        end

        if (fin)
        begin
            phase_next = P_IDLE; bcnt_next = '0; poll_next = '0;
        end
    end

    assign s_new = step_of(phase_next);

    always_comb
    begin
        unique case (s_new.arg)
            A_VOLT:  argv = 32'h0000_01AA;
            A_HCS:   argv = 32'h4000_0000;
            A_ADDR:  argv = addr_next;
            default: argv = 32'h0;
        endcase
        unique case (bcnt_next)
            10'd0:   fb = s_new.cmd;
            10'd1:   fb = argv[31:24];
            10'd2:   fb = argv[23:16];
            10'd3:   fb = argv[15:8];
            10'd4:   fb = argv[7:0];
            default: fb = s_new.crc;
        endcase
        want = phase_next == P_WR_TOKEN ||
               (phase_next == P_WR_DATA && bcnt_next < 10'(BLOCK_BYTES - 1));
    end

    always_comb
    begin
        out_item_t o;
        o = rdo;
        o.fast_clock = fast_next;
        if (act)
        begin
            if (s_new.kind == K_TICK) o.wait_tick = 1'b1;
            else if (s_new.kind != K_NONE)
            begin
                o.tx_valid = 1'b1;
                o.tx_byte = (s_new.kind == K_FRAME) ? fb :
                            (s_new.kind == K_WDATA) ? item.wr_data : s_new.tx;
                o.cs_active = s_new.cs;
                o.want_data = want;
            end
        end
        else
        begin
            o.want_data = want;
            o.wait_tick = s_new.kind == K_TICK;
        end
        if (fin)
        begin
            o.done_res = 1'b1; o.status = fin_st; o.card_type = fin_ty;
        end
        res = o;
    end

endmodule

// ===== hw/rtl/sd_spi_host_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer_top
// SD card SPI-mode host sequencer with item, result and register channels.
// ----------------------------------------------------------------------------
// Each accepted transaction yields one result in the following cycle; a new item is
// taken every cycle as long as the result register is free or being drained
// in the same cycle, so the sustained rate is one item per clock, set by the
// single registered pass through the sequencer's next-state logic.
module sd_spi_host_sequencer_top
    import sdsh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sdsh_in_if.sink    in_ch,
    sdsh_out_if.source out_ch,
    sdsh_cfg_if.sink   cfg_ch
);

    cfg_t      cfg_reg;
    logic      ovalid_reg;
    out_item_t odata_reg;
    out_item_t res;
    logic      step_en;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !ovalid_reg || out_ch.ready;
    assign step_en      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{poll_limit: 4'd10, retry_limit: 10'd1000,
                         tpoll_limit: 4'd10, rounds: 3'd5};
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_idx_t'(cfg_ch.index))
                CFG_POLL:   cfg_reg.poll_limit  <= cfg_ch.wdata[3:0];
                CFG_RETRY:  cfg_reg.retry_limit <= cfg_ch.wdata[9:0];
                CFG_TPOLL:  cfg_reg.tpoll_limit <= cfg_ch.wdata[3:0];
                CFG_ROUNDS: cfg_reg.rounds      <= cfg_ch.wdata[2:0];
                default: ;
            endcase
        end
    end

    sdsh_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_ch.data),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (in_ch.ready)
            ovalid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            odata_reg <= res;
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

endmodule

// ===== hw/rtl/sdsh_checker.sv =====
// ----------------------------------------------------------------------------
// sdsh_checker
// Port-level checks on the sequencer's result channel.
// ----------------------------------------------------------------------------
module sdsh_checker
    import sdsh_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted transaction gave no result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_no_cs_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.tx_valid |-> !out_data.cs_active)
        else $error("chip select without a byte");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.done_res |-> out_data.status == ST_OK
                                            && out_data.card_type == 3'd0)
        else $error("status without completion");

endmodule

bind sd_spi_host_sequencer_top sdsh_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

// ===== tb/sd_spi_host_sequencer_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer_chk
// Watches the item, result and register channels of the SD SPI host
// sequencer, predicts each result from the accepted items and compares it
// field by field with the result the block hands out.
// ----------------------------------------------------------------------------
module sd_spi_host_sequencer_chk
    import sdsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          done_count
);

    logic [3:0]  poll_lim;
    logic [9:0]  retry_lim;
    logic [3:0]  tpoll_lim;
    logic [2:0]  round_lim;
    phase_t      ph;
    logic [2:0]  kind_store;
    logic [9:0]  retries;
    logic [3:0]  polls;
    logic [2:0]  rounds;
    logic [9:0]  nbytes;
    logic [31:0] addr;
    logic [7:0]  last_r1;
    logic [7:0]  ocr0;
    logic        fast;
    logic        fin;
    logic [1:0]  fin_st;
    logic [2:0]  fin_ty;
    out_item_t   expected_q[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        fail_count++;
    endtask

    task automatic go(input phase_t p);
        ph = p;
        nbytes = '0;
        polls = '0;
    endtask

    task automatic finish_req(input logic [1:0] st, input logic [2:0] ty);
        go(P_IDLE);
        fin = 1'b1;
        fin_st = st;
        fin_ty = ty;
    endtask

    task automatic fail_req();
        if (ph <= P_V2_GAPE) finish_req(ST_ERROR, 3'd0);
        else if (ph <= P_WK_TICKB) finish_req(ST_NRDY, kind_store);
        else finish_req(ST_ERROR, kind_store);
    endtask

    task automatic card_found(input logic [2:0] t);
        kind_store = t;
        fast = 1'b1;
        finish_req(ST_OK, t);
    endtask

    function automatic logic want_now();
        return ph == P_WR_TOKEN || (ph == P_WR_DATA && nbytes + 11'd1 < BLOCK_BYTES);
    endfunction

    function automatic logic [7:0] frame_byte(step_t s);
        logic [31:0] a;
        a = s.arg == A_VOLT ? 32'h1AA : s.arg == A_HCS ? 32'h4000_0000 :
            s.arg == A_ADDR ? addr : 32'h0;
        if (nbytes == 0) return s.cmd;
        if (nbytes >= 5) return s.crc;
        return a[8*(4-nbytes) +: 8];
    endfunction

    task automatic step_done(input logic [7:0] rx);
        logic [7:0] r;
        r = last_r1;
        case (ph)
            P_IN_R1B: if (r[2]) begin retries = '0; go(P_V1_C55); end else go(P_V2_SKIP);
            P_V1_GAPB:
                if (r[2]) begin retries = '0; go(P_MM_CMD1); end
                else if (r == 0) card_found(3'd1);
                else go(P_V1_TICK);
            P_MM_GAP: if (r == 0) card_found(3'd2); else go(P_MM_TICK);
            P_V2_GAP: begin retries = '0; go(P_V2_C55A); end
            P_V2_R1B:
                if (r == 1) go(P_V2_C55C);
                else if (r == 0) go(P_V2_CMD58);
                else fail_req();
            P_V2_GAPD: if (r == 0) go(P_V2_CMD58); else go(P_V2_TICK);
            P_V2_GAPE: card_found(ocr0[6] ? 3'd4 : 3'd3);
            P_WK_GAPA, P_WK_GAPC:
                if (r == 0) finish_req(ST_OK, kind_store); else go(phase_t'(ph + 1));
            P_RD_R1, P_WR_R1: if (r != 0) fail_req(); else go(phase_t'(ph + 1));
            P_RD_GAP, P_WR_GAPB: finish_req(ST_OK, kind_store);
            P_WR_RESP: if (rx[4] || rx[3:0] != 4'b0101) fail_req(); else go(P_WR_BUSY);
            default: go(phase_t'(ph + 1));
        endcase
    endtask

    task automatic predict_result(input in_item_t it);
        out_item_t o;
        step_t     s;
        logic      act;
        phase_t    back;
        o = '0;
        fin = 1'b0;
        act = 1'b0;
        s = step_of(ph);
        if (ph == P_IDLE && it.req_type <= REQ_WRITE) begin
            act = 1'b1;
            if (it.req_type == REQ_INIT) begin
                fast = 1'b0;
                go(P_IN_WAKE);
            end
            else if (it.req_type == REQ_WAKE) begin
                if (kind_store == 0) finish_req(ST_NRDY, 3'd0);
                else
                begin
                    fast = 1'b0;
                    retries = '0;
                    go((kind_store == 1 || kind_store == 2) ? P_WK_CMD1 : P_WK_C55);
                end
            end
            else
            begin
                fast = 1'b1;
                rounds = '0;
                addr = kind_store == 4 ? it.sector : {it.sector[22:0], 9'd0};
                go(it.req_type == REQ_READ ? P_RD_CMD : P_WR_CMD);
            end
        end
        else if (it.req_type == REQ_LINK && s.kind != K_NONE && s.kind != K_TICK) begin
            act = 1'b1;
            case (s.kind)
                K_FF, K_FRAME, K_WDATA:
                begin
                    if (ph == P_RD_DATA) begin o.rd_valid = 1'b1; o.rd_byte = it.rx_byte; end
                    if (ph == P_V2_OCR && nbytes == 0) ocr0 = it.rx_byte;
                    nbytes = nbytes + 1;
                    if (nbytes >= s.count) step_done(it.rx_byte);
                end
                K_R1:
                    if (!it.rx_byte[7]) begin
                        last_r1 = it.rx_byte;
                        step_done(it.rx_byte);
                    end
                    else
                    begin
                        polls = polls + 1;
                        if (polls >= poll_lim) fail_req();
                    end
                K_TOKEN:
                    if (it.rx_byte == 8'hFE) step_done(it.rx_byte);
                    else
                    begin
                        polls = polls + 1;
                        if (polls >= tpoll_lim) begin rounds = rounds + 1; go(P_RD_TICK); end
                    end
                K_BUSY: if (it.rx_byte != 0) step_done(it.rx_byte);
                default: ;
            endcase
        end
        else if (it.req_type == REQ_TICK && s.kind == K_TICK) begin
            act = 1'b1;
            if (ph == P_RD_TICK) begin
                if (rounds >= round_lim) fail_req(); else go(P_RD_TOKEN);
            end
            else
            begin
                back = ph == P_V1_TICK ? P_V1_C55 : ph == P_MM_TICK ? P_MM_CMD1 :
                       ph == P_V2_TICK ? P_V2_C55A : ph == P_WK_TICKA ? P_WK_CMD1 : P_WK_C55;
                retries = retries + 1;
                if (retries >= retry_lim) fail_req(); else go(back);
            end
        end
        s = step_of(ph);
        if (act) begin
            if (s.kind == K_TICK) o.wait_tick = 1'b1;
            else if (s.kind != K_NONE) begin
                o.tx_valid = 1'b1;
                o.tx_byte = s.kind == K_FRAME ? frame_byte(s) :
                            s.kind == K_WDATA ? it.wr_data : s.tx;
                o.cs_active = s.cs;
                o.want_data = want_now();
            end
        end
        else
        begin
            o.want_data = want_now();
            o.wait_tick = s.kind == K_TICK;
        end
        o.fast_clock = fast;
        if (fin) begin o.done_res = 1'b1; o.status = fin_st; o.card_type = fin_ty; end
        expected_q.push_back(o);
    endtask

    task automatic compare_result(input out_item_t g);
        out_item_t e;
        if (expected_q.size() == 0) begin
            report("unexpected result", g, 0);
            return;
        end
        e = expected_q.pop_front();
        if (g.done_res) done_count++;
        if (g.tx_valid   !== e.tx_valid)   report("tx_valid", g.tx_valid, e.tx_valid);
        if (g.tx_byte    !== e.tx_byte)    report("tx_byte", g.tx_byte, e.tx_byte);
        if (g.cs_active  !== e.cs_active)  report("cs_active", g.cs_active, e.cs_active);
        if (g.fast_clock !== e.fast_clock) report("fast_clock", g.fast_clock, e.fast_clock);
        if (g.rd_valid   !== e.rd_valid)   report("rd_valid", g.rd_valid, e.rd_valid);
        if (g.rd_byte    !== e.rd_byte)    report("rd_byte", g.rd_byte, e.rd_byte);
        if (g.want_data  !== e.want_data)  report("want_data", g.want_data, e.want_data);
        if (g.wait_tick  !== e.wait_tick)  report("wait_tick", g.wait_tick, e.wait_tick);
        if (g.done_res   !== e.done_res)   report("done_res", g.done_res, e.done_res);
        if (g.status     !== e.status)     report("status", g.status, e.status);
        if (g.card_type  !== e.card_type)  report("card_type", g.card_type, e.card_type);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            poll_lim = 4'd10; retry_lim = 10'd1000; tpoll_lim = 4'd10; round_lim = 3'd5;
            ph = P_IDLE; kind_store = '0; retries = '0; polls = '0; rounds = '0;
            nbytes = '0; addr = '0; last_r1 = 8'hFF; ocr0 = '0; fast = 1'b0;
            fin = 1'b0; fin_st = '0; fin_ty = '0;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
            done_count = 0;
        end
        else
        begin
            if (out_valid && out_ready) compare_result(out_data);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_POLL:   poll_lim  = cfg_wdata[3:0];
                    CFG_RETRY:  retry_lim = cfg_wdata[9:0];
                    CFG_TPOLL:  tpoll_lim = cfg_wdata[3:0];
                    CFG_ROUNDS: round_lim = cfg_wdata[2:0];
                endcase
            end
            if (in_valid && in_ready) predict_result(in_data);
            pending = expected_q.size();
        end
    end

endmodule

// ===== tb/tb_sd_spi_host_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_spi_host_sequencer_top
// Drives the SD SPI host sequencer with directed and random card sessions
// (init, wake, sector read and write over a modelled card link) under random
// gaps and stalls on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_sd_spi_host_sequencer_top;
    import sdsh_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   done_count;
    int   idle_cycles;
    bit   hold_sink;
    int   hold_len;
    int   items_sent;
    out_item_t last_out;

    sdsh_in_if  in_ch();
    sdsh_out_if out_ch();
    sdsh_cfg_if cfg_ch();

    sd_spi_host_sequencer_top u_top (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
    );

    sd_spi_host_sequencer_chk u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready),
        .cfg_index(cfg_ch.index), .cfg_wdata(cfg_ch.wdata),
        .fail_count(fail_count), .pending(pending), .done_count(done_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, plus a long forced hold-off when asked
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_len = 0;
        end
        else if (hold_sink) begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_len > 0) begin
            hold_len--;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) < 7) out_ch.ready <= 1'b1;
        else
        begin
            out_ch.ready <= 1'b0;
            hold_len = gap_len();
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) last_out <= '0;
        else if (out_ch.valid && out_ch.ready) last_out <= out_ch.data;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) items_sent <= 0;
        else if (in_ch.valid && in_ch.ready) items_sent <= items_sent + 1;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) idle_cycles <= 0;
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic int u_chk_items();
        return items_sent;
    endfunction

    // valid stays high after a handshake so items can follow back to back;
    // it is dropped before any gap and whenever the sender waits on results
    task automatic send_item(input req_t rq, input logic [31:0] sec, input logic [7:0] rx,
                             input logic [7:0] wd);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.data <= '{req_type: rq, sector: sec, rx_byte: rx, wr_data: wd};
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_raw(input logic [2:0] rq);
        in_ch.data <= '{req_type: rq, sector: $urandom, rx_byte: $urandom, wr_data: $urandom};
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic end_writes();
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic link(input logic [7:0] rx);
        send_item(REQ_LINK, $urandom, rx, $urandom);
    endtask

    // fetch the latest result of the block once it has drained
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // play a card: answer each link request sensibly with occasional faults
    task automatic card_session(input int steps_max, input int noise);
        int n;
        logic [7:0] rx;
        for (n = 0; n < steps_max; n++) begin
            settle();
            if (last_out.done_res) return;
            if (last_out.wait_tick) begin
                send_item(REQ_TICK, $urandom, $urandom, $urandom);
                continue;
            end
            if ($urandom_range(0, 99) < noise) rx = $urandom;
            else if ($urandom_range(0, 3) == 0) rx = 8'hFF;
            else
                case ($urandom_range(0, 6))
                    0: rx = 8'h00;
                    1: rx = 8'h01;
                    2: rx = 8'h05;
                    3: rx = 8'hFE;
                    4: rx = 8'hE5;
                    5: rx = 8'h40;
                    default: rx = $urandom_range(0, 127);
                endcase
            link(rx);
        end
    endtask

    task automatic random_session();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) send_item(REQ_INIT, $urandom, $urandom, $urandom);
        else if (r < 45) send_item(REQ_WAKE, $urandom, $urandom, $urandom);
        else if (r < 70) send_item(REQ_READ, $urandom, $urandom, $urandom);
        else if (r < 90) send_item(REQ_WRITE, $urandom, $urandom, $urandom);
        else send_raw($urandom_range(4, 7));
        card_session(60, 10);
    endtask

    function automatic logic busy_guess();
        return last_out.tx_valid;
    endfunction

    // abort a long transfer: keep feeding until the request ends
    task automatic finish_session();
        while (1) begin
            settle();
            if (last_out.done_res || (!last_out.tx_valid && !last_out.wait_tick &&
                                      !last_out.want_data && last_out.tx_byte == 0 &&
                                      pending == 0 && !busy_guess())) return;
            if (last_out.wait_tick) send_item(REQ_TICK, $urandom, $urandom, $urandom);
            else link($urandom_range(0, 1) ? 8'hE5 : $urandom);
        end
    endtask

    int k;

    initial begin
        rst_n = 1'b0;
        hold_sink = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_POLL;
        cfg_ch.wdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored items, wake with no card, field extremes
        send_raw(3'd6);
        send_raw(3'd7);
        send_item(REQ_LINK, 32'h0, 8'h00, 8'h00);
        send_item(REQ_TICK, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_item(REQ_WAKE, 32'h0, 8'h0, 8'h0);
        send_item(REQ_READ, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_item(REQ_INIT, 32'h0, 8'h0, 8'h0);
        finish_session();
        drain();

        write_reg(CFG_POLL, 32'd1);
        write_reg(CFG_RETRY, 32'd1);
        write_reg(CFG_TPOLL, 32'd1);
        write_reg(CFG_ROUNDS, 32'd1);
        end_writes();
        for (k = 0; k < 10; k++) random_session();
        finish_session();
        drain();

        write_reg(CFG_POLL, 32'd15);
        write_reg(CFG_RETRY, 32'd1023);
        write_reg(CFG_TPOLL, 32'd15);
        write_reg(CFG_ROUNDS, 32'd7);
        end_writes();
        // long result hold-off while items keep coming
        fork
            begin
                hold_sink = 1'b1;
                repeat (60) @(posedge clk);
                hold_sink = 1'b0;
            end
            begin
                send_item(REQ_INIT, 0, 0, 0);
                for (k = 0; k < 8; k++) link(8'hFF);
            end
        join
        finish_session();
        drain();

        write_reg(CFG_POLL, 32'd4);
        write_reg(CFG_RETRY, 32'd3);
        write_reg(CFG_TPOLL, 32'd3);
        write_reg(CFG_ROUNDS, 32'd2);
        end_writes();
        while (u_chk_items() < 1350) begin
            random_session();
            if ($urandom_range(0, 19) == 0) finish_session();
        end
        finish_session();
        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
